FILE: hdl/ccs_pkg.sv
`default_nettype none

package ccs_pkg;

   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_STRING = 2'd1;
   localparam logic [1:0] MODE_LINE   = 2'd2;
   localparam logic [1:0] MODE_BLOCK  = 2'd3;

   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last_result;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

`default_nettype wire

FILE: hdl/ccs_req_if.sv
`default_nettype none

interface ccs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_stream;

   modport source (output valid, output data_byte, output end_of_stream, input ready);
   modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

`default_nettype wire

FILE: hdl/ccs_rsp_if.sv
`default_nettype none

interface ccs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       last_result;

   modport source (output valid, output out_byte, output byte_valid, output last_result,
                   input ready);
   modport sink (input valid, input out_byte, input byte_valid, input last_result,
                 output ready);
endinterface

`default_nettype wire

FILE: hdl/c_comment_stripper.sv
// C comment stripper.
// The req_ch channel carries one source byte per transaction, with
// end_of_stream set on the final byte of a text. The rsp_ch channel carries
// the bytes that remain once comments are removed; a bare end marker
// (byte_valid low) closes a text whose final byte produced nothing, and
// last_result is set on the final transaction of every text.
// A byte is scanned in the cycle it is accepted and its results enter a
// buffer of OutDepth entries, from which rsp_ch is driven. The block
// accepts one byte per cycle as long as the buffer has room for two
// results. A byte that yields two results always follows a held slash
// that yielded none, so with OutDepth of at least 4 a receiver that takes
// one result per cycle never stalls req_ch.
// When the receiver stalls, the buffer fills and req_ch.ready drops until
// room for two results opens again.
// Reset empties the buffer and returns the scanner to normal text with no
// slash held. End of stream also returns the scanner to that state.
`default_nettype none

module c_comment_stripper #(
   parameter int OutDepth = 4
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ccs_req_if.sink    req_ch,
   ccs_rsp_if.source  rsp_ch
);
   import ccs_pkg::*;

   req_type  req;
   push_type push;
   rsp_type  rsp;
   logic     space_ok;
   logic     accept;

   assign req.data_byte     = req_ch.data_byte;
   assign req.end_of_stream = req_ch.end_of_stream;
   assign req_ch.ready      = space_ok;
   assign accept            = req_ch.valid && space_ok;

   ccs_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req),
      .push   (push)
   );

   ccs_out_fifo #(
      .Depth (OutDepth)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp)
   );

   assign rsp_ch.out_byte    = rsp.out_byte;
   assign rsp_ch.byte_valid  = rsp.byte_valid;
   assign rsp_ch.last_result = rsp.last_result;

endmodule

`default_nettype wire

FILE: hdl/ccs_scan.sv
`default_nettype none

module ccs_scan (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire ccs_pkg::req_type  req,
   output ccs_pkg::push_type      push
);
   import ccs_pkg::*;

   logic [1:0] mode_ff;
   logic [1:0] mode_in;
   logic       pend_ff;
   logic       pend_in;
   logic       star_ff;
   logic       star_in;

   logic [7:0] b;
   logic [1:0] cnt;
   logic [7:0] byte0;
   logic [7:0] byte1;
   logic       valid0;

   assign b = req.data_byte;

   always_comb begin
      mode_in = mode_ff;
      pend_in = pend_ff;
      star_in = star_ff;
      cnt     = 2'd0;
      byte0   = b;
      byte1   = b;
      valid0  = 1'b1;

      case (mode_ff)
         MODE_STRING: begin
            if (b == CH_QUOTE) begin
               mode_in = MODE_NORMAL;
            end
            byte0 = b;
            cnt   = 2'd1;
         end
         MODE_LINE: begin
            if (b == CH_NEWLINE) begin
               mode_in = MODE_NORMAL;
               byte0   = b;
               cnt     = 2'd1;
            end
         end
         MODE_BLOCK: begin
            if (b == CH_SLASH && star_ff) begin
               mode_in = MODE_NORMAL;
               star_in = 1'b0;
            end else begin
               star_in = (b == CH_STAR);
            end
         end
         default: begin
            if (pend_ff) begin
               pend_in = 1'b0;
               if (b == CH_SLASH) begin
                  mode_in = MODE_LINE;
               end else if (b == CH_STAR) begin
                  mode_in = MODE_BLOCK;
                  star_in = 1'b0;
               end else begin
                  // The held slash goes out first, then the byte as plain text.
                  byte0 = CH_SLASH;
                  byte1 = b;
                  cnt   = 2'd2;
                  if (b == CH_QUOTE) begin
                     mode_in = MODE_STRING;
                  end
               end
            end else if (b == CH_SLASH) begin
               pend_in = 1'b1;
            end else begin
               if (b == CH_QUOTE) begin
                  mode_in = MODE_STRING;
               end
               byte0 = b;
               cnt   = 2'd1;
            end
         end
      endcase

      if (req.end_of_stream) begin
         if (pend_in) begin
            // A slash held here means nothing else was produced by this byte.
            byte0 = CH_SLASH;
            cnt   = 2'd1;
         end
         if (cnt == 2'd0) begin
            byte0  = 8'h00;
            valid0 = 1'b0;
            cnt    = 2'd1;
         end
         mode_in = MODE_NORMAL;
         pend_in = 1'b0;
         star_in = 1'b0;
      end

      push.count              = accept ? cnt : 2'd0;
      push.first.out_byte     = byte0;
      push.first.byte_valid   = valid0;
      push.first.last_result  = req.end_of_stream && (cnt == 2'd1);
      push.second.out_byte    = byte1;
      push.second.byte_valid  = 1'b1;
      push.second.last_result = req.end_of_stream;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         pend_ff <= 1'b0;
         star_ff <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         pend_ff <= pend_in;
         star_ff <= star_in;
      end
   end

   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req.end_of_stream |=> mode_ff == MODE_NORMAL && !pend_ff && !star_ff)
      else $error("scanner state not cleared after end of stream");

   a_pend_normal: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> mode_ff == MODE_NORMAL)
      else $error("slash held outside normal text");

   a_star_block: assert property (@(posedge clock) disable iff (reset)
      star_ff |-> mode_ff == MODE_BLOCK)
      else $error("star flag set outside block comment");

endmodule

`default_nettype wire

FILE: hdl/ccs_out_fifo.sv
`default_nettype none

module ccs_out_fifo #(
   parameter int Depth = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ccs_pkg::push_type  push,
   output logic                    space_ok,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output ccs_pkg::rsp_type        out_data
);
   import ccs_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastSlot = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] SpaceLimit = CntW'(Depth - 2);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   rsp_type mem [Depth];

   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] wr_ptr_in;
   logic [PtrW-1:0] wr_next;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [PtrW-1:0] rd_ptr_in;
   logic [CntW-1:0] cnt_ff;
   logic [CntW-1:0] cnt_in;
   logic            pop;

   function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
      return (p == LastSlot) ? '0 : p + PtrW'(1);
   endfunction

   assign pop       = out_valid && out_ready;
   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem[rd_ptr_ff];
   assign space_ok  = (cnt_ff <= SpaceLimit);
   assign wr_next   = bump(wr_ptr_ff);

   always_comb begin
      case (push.count)
         2'd1:    wr_ptr_in = wr_next;
         2'd2:    wr_ptr_in = bump(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff + CntW'(push.count) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FullCnt)
      else $error("result buffer overflow");

   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> cnt_ff <= SpaceLimit)
      else $error("results pushed without room");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd0 && !pop |=> $stable(cnt_ff))
      else $error("result count moved without a push or pop");

endmodule

`default_nettype wire
